// ===== rtl/core/gbsc_pkg.sv =====
// Shared types, register offsets and decode function for the two-bank GPIO block.
// No dependencies; every other file of the block uses it.
package gbsc_pkg;

    localparam int MAX_PINS   = 32;
    localparam int BANK_PINS  = 16;
    localparam int ADDR_W     = 8;
    localparam int DATA_W     = 32;
    localparam int NUM_REGS   = 8;
    localparam int OFS_W      = 7;
    localparam int BANK_BIT   = 7;
    localparam int PIN_COUNT_DEF = 32;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [OFS_W-1:0] OFS_OUT_VALUE  = 7'h00;
    localparam logic [OFS_W-1:0] OFS_OUT_ENABLE = 7'h04;
    localparam logic [OFS_W-1:0] OFS_OPEN_DRAIN = 7'h08;
    localparam logic [OFS_W-1:0] OFS_OUT_INVERT = 7'h0c;
    localparam logic [OFS_W-1:0] OFS_PULLUP     = 7'h18;
    localparam logic [OFS_W-1:0] OFS_PULLDOWN   = 7'h1c;
    localparam logic [OFS_W-1:0] OFS_IN_ENABLE  = 7'h20;
    localparam logic [OFS_W-1:0] OFS_IN_INVERT  = 7'h24;
    localparam logic [OFS_W-1:0] OFS_READBACK   = 7'h30;

    typedef enum logic [2:0] {
        SEL_OUT_VALUE,
        SEL_OUT_ENABLE,
        SEL_OPEN_DRAIN,
        SEL_OUT_INVERT,
        SEL_PULLUP,
        SEL_PULLDOWN,
        SEL_IN_ENABLE,
        SEL_IN_INVERT
    } t_reg_sel;

    typedef logic [NUM_REGS-1:0][MAX_PINS-1:0] t_view;

    typedef struct packed {
        logic     hit;
        logic     readback;
        t_reg_sel sel;
    } t_decode;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pad_in;
    } t_req;

    typedef struct packed {
        logic [BANK_PINS-1:0] read_data;
        logic [MAX_PINS-1:0]  pad_out;
        logic [MAX_PINS-1:0]  pad_drive;
        logic [MAX_PINS-1:0]  pull_up;
        logic [MAX_PINS-1:0]  pull_down;
    } t_rsp;

    function automatic t_decode decode_ofs(input logic [OFS_W-1:0] ofs);
        t_decode d;
        d.hit      = 1'b1;
        d.readback = 1'b0;
        d.sel      = SEL_OUT_VALUE;
        case (ofs)
            OFS_OUT_VALUE:  d.sel = SEL_OUT_VALUE;
            OFS_OUT_ENABLE: d.sel = SEL_OUT_ENABLE;
            OFS_OPEN_DRAIN: d.sel = SEL_OPEN_DRAIN;
            OFS_OUT_INVERT: d.sel = SEL_OUT_INVERT;
            OFS_PULLUP:     d.sel = SEL_PULLUP;
            OFS_PULLDOWN:   d.sel = SEL_PULLDOWN;
            OFS_IN_ENABLE:  d.sel = SEL_IN_ENABLE;
            OFS_IN_INVERT:  d.sel = SEL_IN_INVERT;
            OFS_READBACK: begin
                d.hit      = 1'b0;
                d.readback = 1'b1;
            end
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/core/gbsc_req_if.sv =====
// Request channel of the GPIO block: valid/ready handshake plus bus access payload.
// Widths come from gbsc_pkg.
interface gbsc_req_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [gbsc_pkg::ADDR_W-1:0] address;
    logic [gbsc_pkg::DATA_W-1:0] write_data;
    logic [gbsc_pkg::DATA_W-1:0] pad_in;

    modport source(output valid, command, address, write_data, pad_in, input ready);
    modport sink(input valid, command, address, write_data, pad_in, output ready);
endinterface

// ===== rtl/core/gbsc_rsp_if.sv =====
// Response channel of the GPIO block: valid/ready handshake plus read data and pad controls.
// Widths come from gbsc_pkg.
interface gbsc_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [gbsc_pkg::BANK_PINS-1:0] read_data;
    logic [gbsc_pkg::MAX_PINS-1:0]  pad_out;
    logic [gbsc_pkg::MAX_PINS-1:0]  pad_drive;
    logic [gbsc_pkg::MAX_PINS-1:0]  pull_up;
    logic [gbsc_pkg::MAX_PINS-1:0]  pull_down;

    modport source(output valid, read_data, pad_out, pad_drive, pull_up, pull_down,
                   input ready);
    modport sink(input valid, read_data, pad_out, pad_drive, pull_up, pull_down,
                 output ready);
endinterface

// ===== rtl/core/gbsc_regs.sv =====
// Per-pin control register file with atomic set/clear writes.
// Presents the post-write register values zero-extended to 32 pins; uses gbsc_pkg.
module gbsc_regs #(
    parameter int PIN_COUNT = gbsc_pkg::PIN_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_wr_en,
    input  gbsc_pkg::t_reg_sel          i_sel,
    input  logic                        i_high,
    input  logic [gbsc_pkg::DATA_W-1:0] i_write_data,
    output gbsc_pkg::t_view             o_view
);
    import gbsc_pkg::*;

    logic [NUM_REGS-1:0][PIN_COUNT-1:0] r_regs;
    logic [NUM_REGS-1:0][PIN_COUNT-1:0] n_regs;
    logic [MAX_PINS-1:0]                w_set;
    logic [MAX_PINS-1:0]                w_clr;

    always_comb begin
        if (i_high) begin
            w_set = {i_write_data[BANK_PINS-1:0], {BANK_PINS{1'b0}}};
            w_clr = {i_write_data[DATA_W-1:BANK_PINS], {BANK_PINS{1'b0}}};
        end else begin
            w_set = {{BANK_PINS{1'b0}}, i_write_data[BANK_PINS-1:0]};
            w_clr = {{BANK_PINS{1'b0}}, i_write_data[DATA_W-1:BANK_PINS]};
        end
    end

    always_comb begin
        n_regs = r_regs;
        if (i_wr_en) begin
            n_regs[i_sel] = (r_regs[i_sel] | w_set[PIN_COUNT-1:0]) & ~w_clr[PIN_COUNT-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
        end else begin
            r_regs <= n_regs;
        end
    end

    always_comb begin
        o_view = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            o_view[i][PIN_COUNT-1:0] = n_regs[i];
        end
    end

endmodule

// ===== rtl/core/gbsc_resp.sv =====
// Read multiplexer and pad drive equations for one bus beat.
// Combinational; takes the register view from gbsc_regs and types from gbsc_pkg.
module gbsc_resp (
    input  gbsc_pkg::t_view   i_view,
    input  gbsc_pkg::t_req    i_req,
    input  gbsc_pkg::t_decode i_dec,
    output gbsc_pkg::t_rsp    o_rsp
);
    import gbsc_pkg::*;

    logic [MAX_PINS-1:0] w_word;
    logic [MAX_PINS-1:0] w_pout;

    always_comb begin
        w_word = '0;
        if (i_req.command == CMD_READ) begin
            if (i_dec.hit) begin
                w_word = i_view[i_dec.sel];
            end else if (i_dec.readback) begin
                w_word = (i_req.pad_in ^ i_view[SEL_IN_INVERT]) & i_view[SEL_IN_ENABLE];
            end
        end
    end

    assign w_pout = i_view[SEL_OUT_VALUE] ^ i_view[SEL_OUT_INVERT];

    always_comb begin
        o_rsp.read_data = i_req.address[BANK_BIT] ? w_word[MAX_PINS-1:BANK_PINS]
                                                  : w_word[BANK_PINS-1:0];
        o_rsp.pad_out   = w_pout;
        o_rsp.pad_drive = i_view[SEL_OUT_ENABLE] & ~(i_view[SEL_OPEN_DRAIN] & w_pout);
        o_rsp.pull_up   = i_view[SEL_PULLUP];
        o_rsp.pull_down = i_view[SEL_PULLDOWN];
    end

endmodule

// ===== rtl/core/gpio_bank_set_clear_registers_top.sv =====
// Top level of the two-bank GPIO register block with atomic set/clear writes.
// Instantiates gbsc_regs and gbsc_resp; uses gbsc_pkg, gbsc_req_if and gbsc_rsp_if.
//
// Usage: each request beat on i_req is one bus access. command 0 reads the
// register at address (bit 7 picks the high bank of pins 16 to 31), command 1
// writes it, with data bits 15 to 0 setting pins and bits 31 to 16 clearing
// them; clear wins when both are given. Offset 0x30 reads the inverted,
// enabled pad inputs. Unknown offsets read zero and ignore writes.
// Every request yields exactly one response beat on o_rsp, carrying the read
// data and the pad controls as they stand after that beat's write.
// The request is held in the input register and its response beat is then
// captured in the result register once that register is free or being
// taken by the receiver. Throughput is one beat per cycle while the
// receiver takes responses, set by the single register update and read
// path between the two registers.
// Reset clears all control registers and both stage valids. When the receiver
// stalls, the finished response holds; a further request is taken into the
// input register only while it is empty, then i_req.ready drops.
module gpio_bank_set_clear_registers_top #(
    parameter int PIN_COUNT = gbsc_pkg::PIN_COUNT_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    gbsc_req_if.sink   i_req,
    gbsc_rsp_if.source o_rsp
);
    import gbsc_pkg::*;

    logic    r_req_valid;
    t_req    r_req;
    logic    r_rsp_valid;
    t_rsp    r_rsp;
    logic    w_advance;
    t_decode w_dec;
    t_view   w_view;
    t_rsp    w_rsp;

    assign w_advance   = r_req_valid && (!r_rsp_valid || o_rsp.ready);
    assign i_req.ready = !r_req_valid || w_advance;
    assign w_dec       = decode_ofs(r_req.address[OFS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_req_valid <= i_req.valid;
            end
            if (w_advance) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.command    <= i_req.command;
            r_req.address    <= i_req.address;
            r_req.write_data <= i_req.write_data;
            r_req.pad_in     <= i_req.pad_in;
        end
        if (w_advance) begin
            r_rsp <= w_rsp;
        end
    end

    gbsc_regs #(
        .PIN_COUNT(PIN_COUNT)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (w_advance && (r_req.command == CMD_WRITE) && w_dec.hit),
        .i_sel        (w_dec.sel),
        .i_high       (r_req.address[BANK_BIT]),
        .i_write_data (r_req.write_data),
        .o_view       (w_view)
    );

    gbsc_resp u_resp (
        .i_view (w_view),
        .i_req  (r_req),
        .i_dec  (w_dec),
        .o_rsp  (w_rsp)
    );

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.read_data = r_rsp.read_data;
    assign o_rsp.pad_out   = r_rsp.pad_out;
    assign o_rsp.pad_drive = r_rsp.pad_drive;
    assign o_rsp.pull_up   = r_rsp.pull_up;
    assign o_rsp.pull_down = r_rsp.pull_down;

endmodule
